FILE: src/scmr_pkg.sv
// Package with shared types and constants of the spectrum coadder.
`timescale 1ns / 1ps
package scmr_pkg;
    localparam int SampleWidth = 24;
    localparam int SumWidth    = 32;
    localparam int SqWidth     = 56;
    localparam int CountWidth  = 8;

    localparam logic [0:0] RegPixels   = 1'b0;
    localparam logic [0:0] RegReadouts = 1'b1;

    // Job handed from the front part to the back part.
    typedef struct packed {
        logic signed [SampleWidth-1:0] signal_value;
        logic [SampleWidth-1:0]        error_value;
        logic [15:0]                   pixel;
        logic                          first;
        logic                          final_readout;
        logic                          last_pixel;
        logic [CountWidth-1:0]         count;
    } t_job;
endpackage

FILE: src/scmr_front.sv
// Front part: sequences pixel and readout positions and builds jobs.
`timescale 1ns / 1ps
module scmr_front #(
    parameter int MaxPixels = 8192,
    parameter int MaxReadouts = 255
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_idx,
    input  logic [13:0]             i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [23:0]      i_signal_value,
    input  logic [23:0]             i_error_value,
    output logic                    o_job_valid,
    input  logic                    i_job_full,
    output scmr_pkg::t_job          o_job
);
    logic [13:0] r_npix_raw;
    logic [7:0]  r_nread_raw;
    logic [16:0] r_pix;
    logic [7:0]  r_rd;
    logic [16:0] npix;
    logic [7:0]  nread;
    logic [16:0] idx;
    logic [7:0]  rd;
    logic        fin;
    logic        lastp;
    logic        take;

    always_comb begin
        npix = (r_npix_raw == 14'd0) ? 17'd1 : {3'd0, r_npix_raw};
        if (npix > 17'(MaxPixels)) npix = 17'(MaxPixels);
        nread = (r_nread_raw == 8'd0) ? 8'd1 : r_nread_raw;
        if (32'(nread) > MaxReadouts) nread = 8'(MaxReadouts);
        idx = (r_pix >= npix) ? 17'd0 : r_pix;
        rd  = (r_rd >= nread) ? 8'd0 : r_rd;
        fin = (9'(rd) + 9'd1) >= 9'(nread);
        lastp = (idx + 17'd1) >= npix;
    end

    assign o_stall = i_job_full;
    assign take = i_valid && !i_job_full;
    assign o_job_valid = take;
    assign o_job.signal_value = i_signal_value;
    assign o_job.error_value = i_error_value;
    assign o_job.pixel = idx[15:0];
    assign o_job.first = (rd == 8'd0);
    assign o_job.final_readout = fin;
    assign o_job.last_pixel = lastp;
    assign o_job.count = nread;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_npix_raw <= 14'd1024;
            r_nread_raw <= 8'd1;
            r_pix <= '0;
            r_rd <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == scmr_pkg::RegPixels) r_npix_raw <= i_cfg_data;
            else r_nread_raw <= i_cfg_data[7:0];
            r_pix <= '0;
            r_rd <= '0;
        end else if (take) begin
            if (lastp) begin
                r_pix <= '0;
                r_rd <= fin ? 8'd0 : rd + 8'd1;
            end else begin
                r_pix <= idx + 17'd1;
                r_rd <= rd;
            end
        end
    end
endmodule

FILE: src/scmr_fifo.sv
// Two-entry queue between front and back parts.
`timescale 1ns / 1ps
module scmr_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  scmr_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output scmr_pkg::t_job o_data
);
    scmr_pkg::t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

`ifndef NO_ASSERTIONS
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overflow");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop) else $error("queue underflow");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("bad count");
`endif
endmodule

FILE: src/scmr_back.sv
// Back part: accumulates in memories, then takes roots and divides serially on the final readout.
`timescale 1ns / 1ps
module scmr_back #(
    parameter int MaxPixels = 8192
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  scmr_pkg::t_job        i_job,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [23:0]    o_mean_signal,
    output logic [23:0]           o_combined_error,
    output logic [12:0]           o_pixel_index,
    output logic                  o_last_pixel
);
    localparam int AW = $clog2(MaxPixels);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_READ = 6'b000010, S_ACC = 6'b000100,
        S_SQRT = 6'b001000, S_DIV = 6'b010000, S_OUT = 6'b100000
    } t_state;

    t_state r_state;
    logic signed [31:0] r_sig_mem [MaxPixels];
    logic [55:0]        r_sq_mem  [MaxPixels];
    logic signed [31:0] r_sig_rd;
    logic [55:0]        r_sq_rd;
    scmr_pkg::t_job     r_job;
    logic signed [31:0] r_sum;
    logic [55:0]        r_x;
    logic [55:0]        r_bit;
    logic [55:0]        r_root;
    logic [31:0]        r_qs;   // magnitude of signal quotient / remainder work
    logic [31:0]        r_rs;
    logic [27:0]        r_qe;
    logic [27:0]        r_re;
    logic [5:0]         r_k;
    logic               r_neg;
    logic [47:0]        r_sqin;
    logic [56:0]        sq_sum;
    logic [55:0]        sq_new;
    logic signed [31:0] sig_new;
    logic [32:0]        rs_sh;
    logic [28:0]        re_sh;
    logic [31:0]        mag;

    assign o_pop = (r_state == S_IDLE) && i_job_valid;
    assign o_valid = (r_state == S_OUT);
    assign o_pixel_index = r_job.pixel[12:0];
    assign o_last_pixel = r_job.last_pixel;

    always_comb begin
        sq_sum = {1'b0, r_sq_rd} + {9'd0, r_sqin};
        if (r_job.first) sq_new = {8'd0, r_sqin};
        else if (sq_sum[56]) sq_new = '1;
        else sq_new = sq_sum[55:0];
        sig_new = r_job.first ? 32'(r_job.signal_value)
                              : r_sig_rd + 32'(r_job.signal_value);
        mag = r_sum[31] ? 32'(-r_sum) : 32'(r_sum);
        rs_sh = {r_rs, r_qs[31]};
        re_sh = {r_re, r_qe[27]};
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_sig_rd <= r_sig_mem[r_job.pixel[AW-1:0]];
            r_sq_rd  <= r_sq_mem[r_job.pixel[AW-1:0]];
        end
        if (r_state == S_ACC) begin
            r_sig_mem[r_job.pixel[AW-1:0]] <= sig_new;
            r_sq_mem[r_job.pixel[AW-1:0]]  <= sq_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_job_valid) begin
                    r_job <= i_job;
                    r_sqin <= 48'(i_job.error_value) * 48'(i_job.error_value);
                    r_state <= S_READ;
                end
                S_READ: r_state <= S_ACC;
                S_ACC: begin
                    r_sum <= sig_new;
                    r_x <= sq_new;
                    r_bit <= 56'd1 << 54;
                    r_root <= '0;
                    r_state <= r_job.final_readout ? S_SQRT : S_IDLE;
                end
                S_SQRT: begin
                    if (r_bit == '0) begin
                        r_neg <= r_sum[31];
                        r_qs <= mag;
                        r_rs <= '0;
                        r_qe <= r_root[27:0];
                        r_re <= '0;
                        r_k <= '0;
                        r_state <= S_DIV;
                    end else begin
                        if (r_x >= r_root + r_bit) begin
                            r_x <= r_x - (r_root + r_bit);
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle; the error quotient stops after 28 bits.
                    if (rs_sh >= 33'(r_job.count)) begin
                        r_rs <= 32'(rs_sh - 33'(r_job.count));
                        r_qs <= {r_qs[30:0], 1'b1};
                    end else begin
                        r_rs <= rs_sh[31:0];
                        r_qs <= {r_qs[30:0], 1'b0};
                    end
                    if (r_k < 6'd28) begin
                        if (re_sh >= 29'(r_job.count)) begin
                            r_re <= 28'(re_sh - 29'(r_job.count));
                            r_qe <= {r_qe[26:0], 1'b1};
                        end else begin
                            r_re <= re_sh[27:0];
                            r_qe <= {r_qe[26:0], 1'b0};
                        end
                    end
                    r_k <= r_k + 6'd1;
                    if (r_k == 6'd31) r_state <= S_OUT;
                end
                S_OUT: if (!i_stall) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_mean_signal = r_neg ? -r_qs[23:0] : r_qs[23:0];
    assign o_combined_error = (r_qe[27:24] != 4'd0) ? 24'hFFFFFF : r_qe[23:0];

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result dropped");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == S_READ) else $error("pop not taken");
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_mean_signal) && $stable(o_combined_error)
        && $stable(o_pixel_index) && $stable(o_last_pixel))
        else $error("stalled result changed");
`endif
endmodule

FILE: src/spectrum_coadd_mean_rss.sv
// Top level of the spectrum coadder with mean and root-sum-square error.
`timescale 1ns / 1ps
// Channel | direction | handshake          | payload
// input   | in        | i_valid / o_stall  | i_signal_value, i_error_value
// output  | out       | o_valid / i_stall  | o_mean_signal, o_combined_error,
//         |           |                    | o_pixel_index, o_last_pixel
// config  | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// An item that is not on the final readout passes three steps in the back
// part: queue pop, memory read, accumulate write. On the final readout the
// square-root loop (28 steps) and the 32-step serial divider follow, and
// the result then waits for the output transfer. Reset is synchronous and
// active low; the accumulator memories need no clearing since the first
// readout of each group writes them. The two-entry queue lets up to two
// further input items transfer while a result waits under stall.
module spectrum_coadd_mean_rss #(
    parameter int MAX_PIXELS = 8192,
    parameter int MAX_READOUTS = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [13:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [23:0] i_signal_value,
    input  logic [23:0]        i_error_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [23:0] o_mean_signal,
    output logic [23:0]        o_combined_error,
    output logic [12:0]        o_pixel_index,
    output logic               o_last_pixel
);
    logic           job_valid;
    logic           job_full;
    logic           q_valid;
    logic           q_pop;
    scmr_pkg::t_job job;
    scmr_pkg::t_job q_job;

    scmr_front #(.MaxPixels(MAX_PIXELS), .MaxReadouts(MAX_READOUTS)) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .o_stall, .i_signal_value, .i_error_value,
        .o_job_valid(job_valid), .i_job_full(job_full), .o_job(job)
    );

    scmr_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(job_valid), .i_data(job), .o_full(job_full),
        .i_pop(q_pop), .o_valid(q_valid), .o_data(q_job)
    );

    scmr_back #(.MaxPixels(MAX_PIXELS)) u_back (
        .i_clk, .i_rst_n, .i_job_valid(q_valid), .i_job(q_job), .o_pop(q_pop),
        .o_valid, .i_stall, .o_mean_signal, .o_combined_error,
        .o_pixel_index, .o_last_pixel
    );
endmodule
